// ----- src/ble_pkg.sv -----
// Package for the battery level estimator: widths, types and the Li-ion discharge curve.
// Per-segment span and reciprocal tables are derived by hand from the curve points.
// No dependencies.
package ble_pkg;

  localparam int CURVE_POINTS = 13;
  localparam int SEGS         = CURVE_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGS);

  localparam int MV_W     = 13;  // millivolts, 0..5119
  localparam int PCT_W    = 7;   // percent, 0..100
  localparam int DIFF_W   = 9;   // offset into a segment, below the widest span (300)
  localparam int PROD_W   = DIFF_W + PCT_W;
  localparam int RECIP_W  = 14;  // largest reciprocal is 8738
  localparam int RECIP_SH = 18;  // reciprocal scale, above PROD_W so the estimate is low by <= 1

  localparam logic [7:0] GAUGE_MAX = 8'd100;

  typedef logic [MV_W-1:0]   mv_t;
  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [SEG_W-1:0]  seg_t;
  typedef logic [DIFF_W-1:0] diff_t;
  typedef logic [PROD_W-1:0] prod_t;

  // curve points, highest voltage first
  localparam mv_t CURVE_MV [CURVE_POINTS] = '{
    13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
    13'd3910, 13'd3870, 13'd3800, 13'd3730, 13'd3500, 13'd3200
  };
  localparam pct_t CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
  };

  // segment i runs from point i (upper) down to point i+1 (lower)
  localparam diff_t SEG_MV_SPAN [SEGS] = '{
    9'd50, 9'd40, 9'd30, 9'd60, 9'd40, 9'd30,
    9'd40, 9'd40, 9'd70, 9'd70, 9'd230, 9'd300
  };
  localparam pct_t SEG_PCT_SPAN [SEGS] = '{
    7'd5, 7'd5, 7'd10, 7'd10, 7'd10, 7'd10,
    7'd10, 7'd10, 7'd10, 7'd10, 7'd5, 7'd5
  };
  // floor(2^RECIP_SH / mv span)
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEGS] = '{
    14'd5242, 14'd6553, 14'd8738, 14'd4369, 14'd6553, 14'd8738,
    14'd6553, 14'd6553, 14'd3744, 14'd3744, 14'd1139, 14'd873
  };

  // side-band carried down the pipe alongside the curve arithmetic
  typedef struct packed {
    logic gauge;      // gauge byte usable
    pct_t gauge_pct;
    logic v_ok;
    mv_t  mv;         // zero when the voltage read failed
  } side_t;

endpackage

// ----- src/ble_if.sv -----
// Item channel interfaces for the battery level estimator: reading in, estimate out.
// Depends on ble_pkg.
interface ble_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] soc_word;
  logic        soc_read_ok;
  logic [15:0] vcell_word;
  logic        vcell_read_ok;

  modport source (output valid, soc_word, soc_read_ok, vcell_word, vcell_read_ok,
                  input ready);
  modport sink   (input valid, soc_word, soc_read_ok, vcell_word, vcell_read_ok,
                  output ready);
endinterface

interface ble_out_if import ble_pkg::*;;
  logic valid;
  logic ready;
  pct_t level_percent;
  logic level_valid;
  logic from_curve;
  mv_t  cell_millivolts;

  modport source (output valid, level_percent, level_valid, from_curve, cell_millivolts,
                  input ready);
  modport sink   (input valid, level_percent, level_valid, from_curve, cell_millivolts,
                  output ready);
endinterface

// ----- src/battery_level_estimator.sv -----
// Battery level estimator: a five-stage pipeline; the stage chain is convert, segment
// search, multiply, reciprocal multiply, correct and select. Throughput is one item
// per clock while out ready is high.
// The whole pipe advances together; a stall at the output holds every stage.
// Reset (rst_n, synchronous, active low) clears the stage valid bits only.
// Depends on ble_pkg and the channel interfaces in ble_if.sv.
module battery_level_estimator import ble_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ble_in_if.sink      in_item,
  ble_out_if.source   out_item
);

  // pipe advance: output register empty or being taken
  logic en;

  // stage valid bits
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;

  // side-band per stage
  side_t side1_r, side2_r, side3_r, side4_r;

  // ---------------------------------------------------------------- stage 1
  // mv = code*3125/10000 = code*5/16 exactly, so a shift-add and a shift.
  logic [13:0] code;
  logic [16:0] code_x5;
  side_t       side1_nxt;

  always_comb begin
    code              = in_item.vcell_word[13:0];
    code_x5           = {1'b0, code, 2'b00} + {3'b000, code};
    side1_nxt.v_ok    = in_item.vcell_read_ok;
    side1_nxt.mv      = in_item.vcell_read_ok ? code_x5[16:4] : '0;
    side1_nxt.gauge   = in_item.soc_read_ok && (in_item.soc_word[15:8] <= GAUGE_MAX);
    side1_nxt.gauge_pct = in_item.soc_word[14:8];
  end

  // ---------------------------------------------------------------- stage 2
  // Segment search: one compare per curve point, lowest-index hit wins since the
  // curve falls. At/above the top point or at/below the bottom point clamps.
  seg_t  seg2_nxt,  seg2_r;
  diff_t diff2_nxt, diff2_r;
  pct_t  base2_nxt, base2_r;
  logic  clamp2_nxt, clamp2_r;
  pct_t  cpct2_nxt, cpct2_r;
  mv_t   lo_mv;
  mv_t   mv_off;

  always_comb begin
    seg2_nxt  = '0;
    lo_mv     = CURVE_MV[CURVE_POINTS-1];
    base2_nxt = CURVE_PCT[CURVE_POINTS-1];
    for (int i = SEGS - 1; i >= 0; i--) begin
      if (side1_r.mv >= CURVE_MV[i+1]) begin
        seg2_nxt  = SEG_W'(i);
        lo_mv     = CURVE_MV[i+1];
        base2_nxt = CURVE_PCT[i+1];
      end
    end
    mv_off     = side1_r.mv - lo_mv;
    diff2_nxt  = mv_off[DIFF_W-1:0];
    clamp2_nxt = 1'b0;
    cpct2_nxt  = CURVE_PCT[0];
    if (side1_r.mv >= CURVE_MV[0]) begin
      clamp2_nxt = 1'b1;
      cpct2_nxt  = CURVE_PCT[0];
    end else if (side1_r.mv <= CURVE_MV[CURVE_POINTS-1]) begin
      clamp2_nxt = 1'b1;
      cpct2_nxt  = CURVE_PCT[CURVE_POINTS-1];
    end
  end

  // ---------------------------------------------------------------- stage 3
  // offset * percent span of the segment
  seg_t  seg3_r;
  prod_t prod3_nxt, prod3_r;
  pct_t  base3_r;
  logic  clamp3_r;
  pct_t  cpct3_r;

  assign prod3_nxt = PROD_W'(diff2_r * SEG_PCT_SPAN[seg2_r]);

  // ---------------------------------------------------------------- stage 4
  // quotient estimate by reciprocal; low by at most one
  logic [PROD_W+RECIP_W-1:0] qfull;
  seg_t  seg4_r;
  prod_t prod4_r;
  pct_t  est4_nxt, est4_r;
  pct_t  base4_r;
  logic  clamp4_r;
  pct_t  cpct4_r;

  always_comb begin
    qfull    = prod3_r * SEG_RECIP[seg3_r];
    est4_nxt = PCT_W'(qfull >> RECIP_SH);
  end

  // ---------------------------------------------------------------- stage 5
  // one correction step, then choose between gauge byte, curve and failure
  prod_t back5;
  prod_t rem5;
  pct_t  quot5;
  pct_t  curve_pct5;
  pct_t  level5_nxt;
  logic  lvalid5_nxt, curve5_nxt;
  pct_t  level5_r;
  logic  lvalid5_r, curve5_r;
  mv_t   mv5_r;

  always_comb begin
    back5      = PROD_W'(est4_r * SEG_MV_SPAN[seg4_r]);
    rem5       = prod4_r - back5;
    quot5      = (rem5 >= PROD_W'(SEG_MV_SPAN[seg4_r])) ? est4_r + 7'd1 : est4_r;
    curve_pct5 = clamp4_r ? cpct4_r : base4_r + quot5;
    if (side4_r.gauge) begin
      level5_nxt  = side4_r.gauge_pct;
      lvalid5_nxt = 1'b1;
      curve5_nxt  = 1'b0;
    end else if (side4_r.v_ok) begin
      level5_nxt  = curve_pct5;
      lvalid5_nxt = 1'b1;
      curve5_nxt  = 1'b1;
    end else begin
      level5_nxt  = '0;
      lvalid5_nxt = 1'b0;
      curve5_nxt  = 1'b0;
    end
  end

  // ---------------------------------------------------------------- control
  assign en            = !vld5_r || out_item.ready;
  assign in_item.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_item.valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r  <= side1_nxt;

      side2_r  <= side1_r;
      seg2_r   <= seg2_nxt;
      diff2_r  <= diff2_nxt;
      base2_r  <= base2_nxt;
      clamp2_r <= clamp2_nxt;
      cpct2_r  <= cpct2_nxt;

      side3_r  <= side2_r;
      seg3_r   <= seg2_r;
      prod3_r  <= prod3_nxt;
      base3_r  <= base2_r;
      clamp3_r <= clamp2_r;
      cpct3_r  <= cpct2_r;

      side4_r  <= side3_r;
      seg4_r   <= seg3_r;
      prod4_r  <= prod3_r;
      est4_r   <= est4_nxt;
      base4_r  <= base3_r;
      clamp4_r <= clamp3_r;
      cpct4_r  <= cpct3_r;

      level5_r  <= level5_nxt;
      lvalid5_r <= lvalid5_nxt;
      curve5_r  <= curve5_nxt;
      mv5_r     <= side4_r.mv;
    end
  end

  assign out_item.valid           = vld5_r;
  assign out_item.level_percent   = level5_r;
  assign out_item.level_valid     = lvalid5_r;
  assign out_item.from_curve      = curve5_r;
  assign out_item.cell_millivolts = mv5_r;

  // ---------------------------------------------------------------- checks
  // no estimate means neither gauge nor voltage was usable: everything reads zero
  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && !lvalid5_r) |-> (level5_r == '0 && mv5_r == '0 && !curve5_r))
    else $error("failed estimate carries non-zero fields");

  // a delivered estimate never exceeds full charge
  a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
    vld5_r |-> (level5_r <= 7'd100))
    else $error("level above 100 percent");

  // a curve estimate is always flagged valid
  a_curve_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && curve5_r) |-> lvalid5_r)
    else $error("curve result flagged invalid");

  // an accepted item enters the first stage
  a_enter : assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> vld1_r)
    else $error("accepted item lost at entry");

endmodule
